// File: hw/rtl/card_frame_splitter_unit_defines.svh
// ---------------------------------------------------------------------------
// card frame splitter assertion macros
// shared property forms for the concurrent checks of the splitter
// ---------------------------------------------------------------------------
`ifndef CARD_FRAME_SPLITTER_UNIT_DEFINES_SVH
`define CARD_FRAME_SPLITTER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("card frame splitter check failed");

// next-cycle implication, disabled while reset is low
`define CFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("card frame splitter check failed");

`endif

// File: hw/rtl/cfs_pkg.sv
// ---------------------------------------------------------------------------
// cfs_pkg
// shared constants, types and register codes of the card frame splitter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfs_pkg;

    localparam int PENDING_DEPTH = 12;
    localparam int IDX_W         = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int HELD_W        = $clog2(PENDING_DEPTH + 1);
    localparam int EXTRA_MAX     = 12;
    localparam int EXTRA_LIM     = (PENDING_DEPTH < EXTRA_MAX) ? PENDING_DEPTH : EXTRA_MAX;
    localparam int MAX_RESULTS   = 13;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

    localparam int BYTE_W     = 8;
    localparam int SHORT_W    = 7;
    localparam int EXTRA_W    = 4;
    localparam int TIMER_W    = 16;
    localparam int POS_W      = 7;
    localparam int CNT_W      = SHORT_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SHORT_W-1:0] SHORT_MIN   = 7'd3;
    localparam logic [SHORT_W-1:0] SHORT_RST   = 7'd103;
    localparam logic [EXTRA_W-1:0] EXTRA_RST   = 4'd12;
    localparam logic [TIMER_W-1:0] TIMEOUT_RST = 16'd40;

    localparam logic [BYTE_W-1:0] HDR0 = 8'h23;
    localparam logic [BYTE_W-1:0] HDR1 = 8'h40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LEN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_LEN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

    // item and result codes
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_TICK  = 1'b1;
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;
    localparam logic FT_SHORT = 1'b0;
    localparam logic FT_LONG  = 1'b1;

    typedef struct packed {
        logic [SHORT_W-1:0] short_eff;
        logic [EXTRA_W-1:0] extra_eff;
        logic [TIMER_W-1:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  position;
        logic              frame_type;
    } result_t;

    typedef struct packed {
        logic    push;
        logic    fin;
        result_t res;
    } obuf_req_t;

endpackage

// File: hw/rtl/cfs_pend_ram.sv
// ---------------------------------------------------------------------------
// cfs_pend_ram
// pending byte store: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfs_pend_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [cfs_pkg::IDX_W-1:0]  waddr,
    input  logic [cfs_pkg::BYTE_W-1:0] wdata,
    input  logic                      re,
    input  logic [cfs_pkg::IDX_W-1:0]  raddr,
    output logic [cfs_pkg::BYTE_W-1:0] rdata
);
    import cfs_pkg::*;

    logic [BYTE_W-1:0] pend_mem [PENDING_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            pend_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= pend_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/cfs_cfg_regs.sv
// ---------------------------------------------------------------------------
// cfs_cfg_regs
// configuration registers with range limiting of the lengths
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfs_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfs_pkg::CFG_DATA_W-1:0] cfg_data,
    output cfs_pkg::cfg_t                 cfg
);
    import cfs_pkg::*;

    logic [SHORT_W-1:0] short_reg;
    logic [EXTRA_W-1:0] extra_reg;
    logic [TIMER_W-1:0] timeout_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg   <= SHORT_RST;
            extra_reg   <= EXTRA_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SHORT_LEN:     short_reg   <= cfg_data[SHORT_W-1:0];
                REG_EXTRA_LEN:     extra_reg   <= cfg_data[EXTRA_W-1:0];
                REG_TIMEOUT_TICKS: timeout_reg <= cfg_data[TIMER_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        cfg.short_eff = (short_reg < SHORT_MIN) ? SHORT_MIN : short_reg;
        if (extra_reg == '0)
        begin
            cfg.extra_eff = EXTRA_W'(1);
        end
        else if (extra_reg > EXTRA_W'(EXTRA_LIM))
        begin
            cfg.extra_eff = EXTRA_W'(EXTRA_LIM);
        end
        else
        begin
            cfg.extra_eff = extra_reg;
        end
        // a zero timeout fires on the first tick, same as one
        cfg.timeout = timeout_reg;
    end

endmodule

// File: hw/rtl/cfs_out_buf.sv
// ---------------------------------------------------------------------------
// cfs_out_buf
// result lookahead and output register: marks the last result of an item
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfs_out_buf (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfs_pkg::obuf_req_t         req,
    output logic                       rdy,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic                       kind,
    output logic [cfs_pkg::BYTE_W-1:0] data_byte,
    output logic [cfs_pkg::POS_W-1:0]  position,
    output logic                       frame_type,
    output logic                       last
);
    import cfs_pkg::*;

    logic    hold_v_reg, hold_v_next;
    logic    out_v_reg, out_v_next;
    result_t hold_reg, hold_next;
    result_t out_reg, out_next;
    logic    out_last_reg, out_last_next;
    logic    out_free;

    assign out_free = !out_v_reg || !result_stall;
    assign rdy      = !hold_v_reg || out_free;

    always_comb
    begin
        hold_v_next   = hold_v_reg;
        hold_next     = hold_reg;
        out_v_next    = out_v_reg;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        if (out_v_reg && !result_stall)
        begin
            out_v_next = 1'b0;
        end
        if (req.push && rdy)
        begin
            // a newer result means the held one is not the last
            if (hold_v_reg)
            begin
                out_next      = hold_reg;
                out_last_next = 1'b0;
                out_v_next    = 1'b1;
            end
            hold_next   = req.res;
            hold_v_next = 1'b1;
        end
        else if (req.fin && rdy && hold_v_reg)
        begin
            out_next      = hold_reg;
            out_last_next = 1'b1;
            out_v_next    = 1'b1;
            hold_v_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            hold_v_reg <= hold_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign result_valid = out_v_reg;
    assign kind         = out_reg.kind;
    assign data_byte    = out_reg.data_byte;
    assign position     = out_reg.position;
    assign frame_type   = out_reg.frame_type;
    assign last         = out_last_reg;

endmodule

// File: hw/rtl/cfs_ctrl.sv
// ---------------------------------------------------------------------------
// cfs_ctrl
// frame sequencer: header hunt, frame counting, hold, completion, rescan
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "card_frame_splitter_unit_defines.svh"

module cfs_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfs_pkg::cfg_t              cfg,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic                       op,
    input  logic [cfs_pkg::BYTE_W-1:0] rx_byte,
    output logic                       ram_we,
    output logic [cfs_pkg::IDX_W-1:0]  ram_waddr,
    output logic [cfs_pkg::BYTE_W-1:0] ram_wdata,
    output logic                       ram_re,
    output logic [cfs_pkg::IDX_W-1:0]  ram_raddr,
    input  logic [cfs_pkg::BYTE_W-1:0] ram_rdata,
    output cfs_pkg::obuf_req_t         obuf_req,
    input  logic                       obuf_rdy
);
    import cfs_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_TICK  = 11'b000_0000_0010,
        S_BYTE  = 11'b000_0000_0100,
        S_HDR0  = 11'b000_0000_1000,
        S_HDR1  = 11'b000_0001_0000,
        S_LRD   = 11'b000_0010_0000,
        S_LEMIT = 11'b000_0100_0000,
        S_LEND  = 11'b000_1000_0000,
        S_TMO   = 11'b001_0000_0000,
        S_NEXT  = 11'b010_0000_0000,
        S_FIN   = 11'b100_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        HUNT_SEARCH = 2'd0,
        HUNT_HASH   = 2'd1,
        HUNT_FRAME  = 2'd2
    } hunt_t;

    state_t             state_reg, state_next;
    hunt_t              hunt_reg, hunt_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               waiting_reg, waiting_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [HELD_W-1:0]  held_reg, held_next;
    logic [BYTE_W-1:0]  cur_byte_reg, cur_byte_next;
    logic               scan_reg, scan_next;
    logic [HELD_W-1:0]  scan_i_reg, scan_i_next;
    logic [HELD_W-1:0]  scan_n_reg, scan_n_next;
    logic [HELD_W-1:0]  emit_i_reg, emit_i_next;
    logic [HELD_W-1:0]  emit_n_reg, emit_n_next;
    logic [CNT_W-1:0]   base_reg, base_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;

    logic [BYTE_W-1:0]  byte_val;
    logic [CNT_W-1:0]   cnt_inc;
    logic [HELD_W-1:0]  held_inc;
    logic [HELD_W-1:0]  scan_i_inc;
    logic [HELD_W-1:0]  emit_i_inc;
    logic [HELD_W-1:0]  extra_eff_h;
    logic               push_req;
    logic               drop;
    logic               push_go;
    result_t            push_res;

    // rescanned bytes come straight from the store read register
    assign byte_val    = scan_reg ? ram_rdata : cur_byte_reg;
    assign cnt_inc     = count_reg + CNT_W'(1);
    assign held_inc    = held_reg + HELD_W'(1);
    assign scan_i_inc  = scan_i_reg + HELD_W'(1);
    assign emit_i_inc  = emit_i_reg + HELD_W'(1);
    assign extra_eff_h = HELD_W'(cfg.extra_eff);

    // results past the per-item cap are dropped without waiting
    assign drop    = (res_cnt_reg >= RES_CNT_W'(MAX_RESULTS));
    assign push_go = push_req && (drop || obuf_rdy);

    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        hunt_next     = hunt_reg;
        count_next    = count_reg;
        waiting_next  = waiting_reg;
        timer_next    = timer_reg;
        held_next     = held_reg;
        cur_byte_next = cur_byte_reg;
        scan_next     = scan_reg;
        scan_i_next   = scan_i_reg;
        scan_n_next   = scan_n_reg;
        emit_i_next   = emit_i_reg;
        emit_n_next   = emit_n_reg;
        base_next     = base_reg;
        res_cnt_next  = res_cnt_reg;

        push_req  = 1'b0;
        push_res  = '0;
        ram_we    = 1'b0;
        ram_waddr = held_reg[IDX_W-1:0];
        ram_wdata = byte_val;
        ram_re    = 1'b0;
        ram_raddr = '0;
        obuf_req.fin = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    res_cnt_next = '0;
                    scan_next    = 1'b0;
                    if (op == OP_BYTE)
                    begin
                        cur_byte_next = rx_byte;
                        state_next    = S_BYTE;
                    end
                    else
                    begin
                        state_next = S_TICK;
                    end
                end
            end

            S_TICK:
            begin
                if (!waiting_reg)
                begin
                    state_next = S_FIN;
                end
                else if (timer_reg > TIMER_W'(1))
                begin
                    timer_next = timer_reg - TIMER_W'(1);
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_TMO;
                end
            end

            S_TMO:
            begin
                push_req            = 1'b1;
                push_res.kind       = KIND_END;
                push_res.frame_type = FT_SHORT;
                if (push_go)
                begin
                    scan_n_next  = held_reg;
                    scan_i_next  = '0;
                    hunt_next    = HUNT_SEARCH;
                    count_next   = '0;
                    waiting_next = 1'b0;
                    timer_next   = '0;
                    held_next    = '0;
                    if (held_reg != '0)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        scan_next  = 1'b1;
                        state_next = S_BYTE;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_BYTE:
            begin
                case (hunt_reg)
                    HUNT_FRAME:
                    begin
                        if (!waiting_reg)
                        begin
                            push_req           = 1'b1;
                            push_res.kind      = KIND_DATA;
                            push_res.data_byte = byte_val;
                            push_res.position  = count_reg[POS_W-1:0];
                            if (push_go)
                            begin
                                count_next = cnt_inc;
                                if (cnt_inc >= CNT_W'(cfg.short_eff))
                                begin
                                    waiting_next = 1'b1;
                                    timer_next   = cfg.timeout;
                                    held_next    = '0;
                                end
                                state_next = scan_reg ? S_NEXT : S_FIN;
                            end
                        end
                        else
                        begin
                            // hold the byte; write index stays behind the rescan read
                            ram_we     = (held_reg < HELD_W'(PENDING_DEPTH));
                            held_next  = held_inc;
                            count_next = cnt_inc;
                            if (held_inc >= extra_eff_h)
                            begin
                                base_next   = count_reg - CNT_W'(held_reg);
                                emit_n_next = extra_eff_h;
                                emit_i_next = '0;
                                state_next  = S_LRD;
                            end
                            else
                            begin
                                state_next = scan_reg ? S_NEXT : S_FIN;
                            end
                        end
                    end

                    HUNT_HASH:
                    begin
                        if (byte_val == HDR1)
                        begin
                            hunt_next  = HUNT_FRAME;
                            count_next = '0;
                            state_next = S_HDR0;
                        end
                        else
                        begin
                            hunt_next  = (byte_val == HDR0) ? HUNT_HASH : HUNT_SEARCH;
                            state_next = scan_reg ? S_NEXT : S_FIN;
                        end
                    end

                    default:
                    begin
                        hunt_next  = (byte_val == HDR0) ? HUNT_HASH : HUNT_SEARCH;
                        state_next = scan_reg ? S_NEXT : S_FIN;
                    end
                endcase
            end

            S_HDR0:
            begin
                push_req           = 1'b1;
                push_res.kind      = KIND_DATA;
                push_res.data_byte = HDR0;
                push_res.position  = POS_W'(0);
                if (push_go)
                begin
                    state_next = S_HDR1;
                end
            end

            S_HDR1:
            begin
                // short length is at least three, so no hold starts here
                push_req           = 1'b1;
                push_res.kind      = KIND_DATA;
                push_res.data_byte = HDR1;
                push_res.position  = POS_W'(1);
                if (push_go)
                begin
                    count_next = CNT_W'(2);
                    state_next = scan_reg ? S_NEXT : S_FIN;
                end
            end

            S_LRD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = emit_i_reg[IDX_W-1:0];
                state_next = S_LEMIT;
            end

            S_LEMIT:
            begin
                push_req           = 1'b1;
                push_res.kind      = KIND_DATA;
                push_res.data_byte = ram_rdata;
                push_res.position  = POS_W'(base_reg + CNT_W'(emit_i_reg));
                if (push_go)
                begin
                    if (emit_i_inc < emit_n_reg)
                    begin
                        ram_re      = 1'b1;
                        ram_raddr   = emit_i_inc[IDX_W-1:0];
                        emit_i_next = emit_i_inc;
                    end
                    else
                    begin
                        state_next = S_LEND;
                    end
                end
            end

            S_LEND:
            begin
                push_req            = 1'b1;
                push_res.kind       = KIND_END;
                push_res.frame_type = FT_LONG;
                if (push_go)
                begin
                    hunt_next    = HUNT_SEARCH;
                    count_next   = '0;
                    waiting_next = 1'b0;
                    timer_next   = '0;
                    held_next    = '0;
                    state_next   = scan_reg ? S_NEXT : S_FIN;
                end
            end

            S_NEXT:
            begin
                if (scan_i_inc < scan_n_reg)
                begin
                    ram_re      = 1'b1;
                    ram_raddr   = scan_i_inc[IDX_W-1:0];
                    scan_i_next = scan_i_inc;
                    state_next  = S_BYTE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                obuf_req.fin = 1'b1;
                if (obuf_rdy)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push_req && !drop && obuf_rdy)
        begin
            res_cnt_next = res_cnt_reg + RES_CNT_W'(1);
        end

        obuf_req.push = push_req && !drop;
        obuf_req.res  = push_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            hunt_reg    <= HUNT_SEARCH;
            count_reg   <= '0;
            waiting_reg <= 1'b0;
            timer_reg   <= '0;
            held_reg    <= '0;
            scan_reg    <= 1'b0;
            scan_i_reg  <= '0;
            scan_n_reg  <= '0;
            emit_i_reg  <= '0;
            emit_n_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            hunt_reg    <= hunt_next;
            count_reg   <= count_next;
            waiting_reg <= waiting_next;
            timer_reg   <= timer_next;
            held_reg    <= held_next;
            scan_reg    <= scan_next;
            scan_i_reg  <= scan_i_next;
            scan_n_reg  <= scan_n_next;
            emit_i_reg  <= emit_i_next;
            emit_n_reg  <= emit_n_next;
            res_cnt_reg <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_byte_reg <= cur_byte_next;
        base_reg     <= base_next;
    end

    `CFS_ASSERT_IMP(a_wait_in_frame, clk, rst_n, waiting_reg, hunt_reg == HUNT_FRAME)
    `CFS_ASSERT_IMP(a_held_bound, clk, rst_n, 1'b1, held_reg <= HELD_W'(PENDING_DEPTH))
    `CFS_ASSERT_IMP(a_res_cap, clk, rst_n, obuf_req.push, res_cnt_reg < RES_CNT_W'(MAX_RESULTS))
    `CFS_ASSERT_NXT(a_accept_busy, clk, rst_n, item_valid && (state_reg == S_IDLE), state_reg != S_IDLE)

endmodule

// File: hw/rtl/card_frame_splitter_unit.sv
// ---------------------------------------------------------------------------
// card_frame_splitter_unit
// cuts a serial byte stream into card frames with short and long endings
// ---------------------------------------------------------------------------
// usage:
//   item channel (item_valid/item_stall): op 0 carries a received byte in
//   rx_byte, op 1 is one timer tick. one request is worked on at a time.
//   result channel (result_valid/result_stall): frame bytes with their
//   position, or an end marker with frame_type; last flags the final result
//   of a request. a request may give no result at all.
//   config channel (cfg_valid/cfg_ready): index 0 short length, 1 extra
//   length, 2 timeout ticks; always ready, write only while idle.
//   timing: a long-frame completion reads the held bytes back from the
//   pending store one at a time, and a timeout rescan reads each held byte
//   from the store's registered read port before working on it again.
//   reset: hunting for a header, defaults 103 / 12 / 40, no clearing pass.
//   a stalled receiver holds the current result; the unit works on into a
//   one-deep lookahead, then waits; only results past 13 per request drop.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module card_frame_splitter_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic                           op,
    input  logic [cfs_pkg::BYTE_W-1:0]     rx_byte,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic                           kind,
    output logic [cfs_pkg::BYTE_W-1:0]     data_byte,
    output logic [cfs_pkg::POS_W-1:0]      position,
    output logic                           frame_type,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cfs_pkg::*;

    cfg_t              cfg;
    obuf_req_t         obuf_req;
    logic              obuf_rdy;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    cfs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cfs_pend_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cfs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .op         (op),
        .rx_byte    (rx_byte),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .obuf_req   (obuf_req),
        .obuf_rdy   (obuf_rdy)
    );

    cfs_out_buf u_obuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (obuf_req),
        .rdy          (obuf_rdy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .position     (position),
        .frame_type   (frame_type),
        .last         (last)
    );

endmodule

// File: bench/tb_card_frame_splitter_unit.sv
// ---------------------------------------------------------------------------
// tb_card_frame_splitter_unit
// drives byte and tick requests into the frame splitter, predicts every frame
// byte and end marker in a local model of the splitter and checks each result
// in order, with random gaps on the request side and random result stalls
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_card_frame_splitter_unit;

    import cfs_pkg::*;

    localparam int SETTLE_CYCLES = 60;

    typedef enum logic [1:0] {SCAN_HUNT, SCAN_HASH, SCAN_FRAME} scan_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  position;
        logic              frame_type;
        logic              last;
    } out_rec_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    logic                  op = OP_BYTE;
    logic [BYTE_W-1:0]     rx_byte = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic                  kind;
    logic [BYTE_W-1:0]     data_byte;
    logic [POS_W-1:0]      position;
    logic                  frame_type;
    logic                  last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // splitter model state
    logic [SHORT_W-1:0] short_reg = SHORT_RST;
    logic [EXTRA_W-1:0] extra_reg = EXTRA_RST;
    logic [TIMER_W-1:0] timeout_reg = TIMEOUT_RST;
    scan_t              scan = SCAN_HUNT;
    int unsigned        frame_cnt = 0;
    bit                 holding = 1'b0;
    int unsigned        ticks_left = 0;
    logic [BYTE_W-1:0]  held_q [PENDING_DEPTH];
    int unsigned        held_cnt = 0;

    out_rec_t           burst_q [$];
    out_rec_t           expected_q [$];
    int                 errors = 0;
    int                 items_sent = 0;
    bit                 idling = 1'b1;
    int                 stall_hold = 0;

    card_frame_splitter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .rx_byte      (rx_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .position     (position),
        .frame_type   (frame_type),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    function automatic int unsigned short_eff();
        return (short_reg < SHORT_MIN) ? int'(SHORT_MIN) : int'(short_reg);
    endfunction

    function automatic int unsigned extra_eff();
        int unsigned e;
        e = extra_reg;
        if (e < 1)
            e = 1;
        if (e > EXTRA_LIM)
            e = EXTRA_LIM;
        return e;
    endfunction

    function automatic void add_result(logic k, logic [BYTE_W-1:0] b, int unsigned pos,
                                       logic ft);
        out_rec_t r;
        // anything past the per-request result cap is lost
        if (burst_q.size() >= MAX_RESULTS)
            return;
        r.kind       = k;
        r.data_byte  = b;
        r.position   = POS_W'(pos);
        r.frame_type = ft;
        r.last       = 1'b0;
        burst_q.push_back(r);
    endfunction

    function automatic void close_frame();
        holding    = 1'b0;
        ticks_left = 0;
        held_cnt   = 0;
        frame_cnt  = 0;
        scan       = SCAN_HUNT;
    endfunction

    function automatic void emit_data(logic [BYTE_W-1:0] b);
        add_result(KIND_DATA, b, frame_cnt, FT_SHORT);
        frame_cnt++;
        if (frame_cnt >= short_eff())
        begin
            holding    = 1'b1;
            ticks_left = timeout_reg;
            held_cnt   = 0;
        end
    endfunction

    function automatic void feed_byte(logic [BYTE_W-1:0] b);
        int unsigned lim;
        int unsigned base;
        if (scan == SCAN_FRAME)
        begin
            if (!holding)
            begin
                emit_data(b);
                return;
            end
            if (held_cnt < PENDING_DEPTH)
                held_q[held_cnt] = b;
            held_cnt++;
            frame_cnt++;
            lim = extra_eff();
            if (held_cnt >= lim)
            begin
                // only the first lim held bytes go out, the rest is dropped
                base = frame_cnt - held_cnt;
                for (int i = 0; i < lim; i++)
                    add_result(KIND_DATA, held_q[i], base + i, FT_SHORT);
                add_result(KIND_END, '0, 0, FT_LONG);
                close_frame();
            end
            return;
        end
        if (scan == SCAN_HASH && b == HDR1)
        begin
            scan      = SCAN_FRAME;
            frame_cnt = 0;
            emit_data(HDR0);
            emit_data(HDR1);
            return;
        end
        scan = (b == HDR0) ? SCAN_HASH : SCAN_HUNT;
    endfunction

    function automatic void feed_tick();
        logic [BYTE_W-1:0] snap [PENDING_DEPTH];
        int unsigned       n;
        if (!holding)
            return;
        if (ticks_left > 1)
        begin
            ticks_left--;
            return;
        end
        n    = (held_cnt < PENDING_DEPTH) ? held_cnt : PENDING_DEPTH;
        snap = held_q;
        add_result(KIND_END, '0, 0, FT_SHORT);
        close_frame();
        // held bytes are scanned again from the hunting state
        for (int i = 0; i < n; i++)
            feed_byte(snap[i]);
    endfunction

    function automatic void predict_request(logic req_op, logic [BYTE_W-1:0] b);
        burst_q.delete();
        if (req_op == OP_BYTE)
            feed_byte(b);
        else
            feed_tick();
        if (burst_q.size() > 0)
            burst_q[burst_q.size() - 1].last = 1'b1;
        foreach (burst_q[i])
            expected_q.push_back(burst_q[i]);
    endfunction

    // ------------------------------------------------------------- drivers

    task automatic send_item(input logic req_op, input logic [BYTE_W-1:0] b);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item_valid <= 1'b1;
        op         <= req_op;
        rx_byte    <= b;
        do @(posedge clk); while (item_stall);
        predict_request(req_op, b);
        items_sent++;
    endtask

    // drop valid, wait for every expected result, then let the unit go quiet
    task automatic settle();
        item_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] short_val,
                               input logic [CFG_DATA_W-1:0] extra_val,
                               input logic [CFG_DATA_W-1:0] timeout_val);
        logic [CFG_IDX_W-1:0]  idx  [3];
        logic [CFG_DATA_W-1:0] vals [3];
        idx[0]  = REG_SHORT_LEN;
        idx[1]  = REG_EXTRA_LEN;
        idx[2]  = REG_TIMEOUT_TICKS;
        vals[0] = short_val;
        vals[1] = extra_val;
        vals[2] = timeout_val;
        cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            case (idx[i])
                REG_SHORT_LEN:     short_reg   = vals[i][SHORT_W-1:0];
                REG_EXTRA_LEN:     extra_reg   = vals[i][EXTRA_W-1:0];
                REG_TIMEOUT_TICKS: timeout_reg = vals[i][TIMER_W-1:0];
                default:           ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // well-formed frames with random content, some noise and broken headers
    task automatic run_traffic(input int budget);
        int                stop_at;
        int                body_len;
        logic [BYTE_W-1:0] b;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(OP_BYTE, BYTE_W'($urandom));
            if ($urandom_range(0, 7) == 0)
            begin
                send_item(OP_BYTE, HDR0);
                send_item(OP_BYTE, BYTE_W'($urandom));
            end
            if ($urandom_range(0, 7) == 0)
                send_item(OP_BYTE, HDR0);
            send_item(OP_BYTE, HDR0);
            send_item(OP_BYTE, HDR1);
            body_len = short_eff() - 2 + $urandom_range(0, extra_eff() + 1);
            for (int i = 0; i < body_len; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                    send_item(OP_TICK, BYTE_W'($urandom));
                case ($urandom_range(0, 7))
                    0:       b = HDR0;
                    1:       b = HDR1;
                    default: b = BYTE_W'($urandom);
                endcase
                send_item(OP_BYTE, b);
            end
            repeat ($urandom_range(0, 6)) send_item(OP_TICK, BYTE_W'($urandom));
        end
    endtask

    // result stalls in random bursts while idling is set
    always @(posedge clk)
    begin
        if (stall_hold != 0)
        begin
            stall_hold   <= stall_hold - 1;
            result_stall <= 1'b1;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            stall_hold   <= $urandom_range(0, 5);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : check_results
        out_rec_t got;
        out_rec_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = {kind, data_byte, position, frame_type, last};
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result kind %0d byte %02h pos %0d type %0d last %0d",
                         $time, got.kind, got.data_byte, got.position, got.frame_type,
                         got.last);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: expected kind %0d byte %02h pos %0d type %0d last %0d",
                             $time, want.kind, want.data_byte, want.position,
                             want.frame_type, want.last);
                    $display("%0t:   actual kind %0d byte %02h pos %0d type %0d last %0d",
                             $time, got.kind, got.data_byte, got.position, got.frame_type,
                             got.last);
                end
            end
        end
    end

    // --------------------------------------------------------------- tests

    // tick while hunting, noise, split header, held byte, long end
    task automatic test_header_and_long_end();
        load_config(16'd3, 16'd2, 16'd2);
        send_item(OP_TICK, 8'h00);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, HDR0);
        send_item(OP_BYTE, HDR0);
        send_item(OP_BYTE, HDR1);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h43);
        send_item(OP_BYTE, 8'h44);
        settle();
    endtask

    // out-of-range registers, extra length cut mid-frame, then a timeout whose
    // rescan gives more results than one request may carry
    task automatic test_rescan_overflow();
        logic [BYTE_W-1:0] held [11];
        held = '{HDR0, HDR1, 8'h78, 8'h79, HDR0, HDR1, 8'h78, 8'h79, HDR0, HDR1, 8'h78};
        load_config(16'hFF80, 16'hFFFF, 16'h0000);
        send_item(OP_BYTE, HDR0);
        send_item(OP_BYTE, HDR1);
        send_item(OP_BYTE, 8'h61);
        foreach (held[i])
            send_item(OP_BYTE, held[i]);
        settle();
        load_config(16'hFF80, 16'h0001, 16'h0000);
        send_item(OP_TICK, 8'hA5);
        send_item(OP_TICK, 8'h5A);
        settle();
    endtask

    // longest short frame so the held bytes wrap the position field
    task automatic test_wrapped_position();
        load_config(16'd127, 16'd2, 16'hFFFF);
        send_item(OP_BYTE, HDR0);
        send_item(OP_BYTE, HDR1);
        for (int i = 0; i < 127; i++)
            send_item(OP_BYTE, BYTE_W'($urandom));
        settle();
    endtask

    task automatic test_random_settings();
        load_config(16'd3, 16'd1, 16'd1);
        run_traffic(1);
        settle();
        for (int p = 0; p < 2; p++)
        begin
            load_config({9'($urandom), 7'($urandom_range(0, 10))},
                        {12'($urandom), 4'($urandom_range(0, 15))},
                        16'($urandom_range(0, 5)));
            if (p == 1)
                idling = 1'b0;
            run_traffic(1);
            settle();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_header_and_long_end();
        test_rescan_overflow();
        test_wrapped_position();
        test_random_settings();
        if (errors == 0)
            $display("tb_card_frame_splitter_unit OK");
        else
            $display("tb_card_frame_splitter_unit NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_card_frame_splitter_unit NOT OK");
        $finish;
    end

endmodule
